>>> rtl/rf3_pkg.sv
`default_nettype none

package rf3_pkg;

  localparam int PIXEL_BITS = 8;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  // One row of the window after the lane sort: lo <= mid <= hi
  typedef struct packed {
    pix_t lo;
    pix_t mid;
    pix_t hi;
  } trio_t;

  localparam logic [1:0] MODE_MEDIAN  = 2'd0;
  localparam logic [1:0] MODE_MINIMUM = 2'd1;
  localparam logic [1:0] MODE_MAXIMUM = 2'd2;

  localparam logic ADDR_RANK_MODE = 1'b0;

  function automatic pix_t min2(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

`default_nettype wire

>>> rtl/rf3_lane.sv
`default_nettype none

module rf3_lane (
  input  wire rf3_pkg::pix_t  a,
  input  wire rf3_pkg::pix_t  b,
  input  wire rf3_pkg::pix_t  c,
  output rf3_pkg::trio_t      sorted
);

  rf3_pkg::pix_t lo1, hi1, lo2;

  // Three compare-exchange steps sort one row
  always_comb begin
    lo1        = rf3_pkg::min2(a, b);
    hi1        = rf3_pkg::max2(a, b);
    lo2        = rf3_pkg::min2(hi1, c);
    sorted.hi  = rf3_pkg::max2(hi1, c);
    sorted.lo  = rf3_pkg::min2(lo1, lo2);
    sorted.mid = rf3_pkg::max2(lo1, lo2);
  end

endmodule

`default_nettype wire

>>> rtl/rf3_merge.sv
`default_nettype none

module rf3_merge (
  input  wire rf3_pkg::trio_t row0,
  input  wire rf3_pkg::trio_t row1,
  input  wire rf3_pkg::trio_t row2,
  input  wire [1:0]           rank_mode,
  input  wire rf3_pkg::pix_t  center,
  input  wire                 on_border,
  output rf3_pkg::pix_t       filtered
);

  rf3_pkg::pix_t max_lo, med_mid, min_hi, min_all, max_all, median;

  always_comb begin
    max_lo  = rf3_pkg::max2(rf3_pkg::max2(row0.lo, row1.lo), row2.lo);
    med_mid = rf3_pkg::med3(row0.mid, row1.mid, row2.mid);
    min_hi  = rf3_pkg::min2(rf3_pkg::min2(row0.hi, row1.hi), row2.hi);
    min_all = rf3_pkg::min2(rf3_pkg::min2(row0.lo, row1.lo), row2.lo);
    max_all = rf3_pkg::max2(rf3_pkg::max2(row0.hi, row1.hi), row2.hi);
    // Median of nine from the row-sorted window
    median  = rf3_pkg::med3(max_lo, med_mid, min_hi);

    if (on_border) begin
      filtered = center;
    end else begin
      case (rank_mode)
        rf3_pkg::MODE_MINIMUM: filtered = min_all;
        rf3_pkg::MODE_MAXIMUM: filtered = max_all;
        default:               filtered = median;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/rank_filter_3x3_unit.sv
`default_nettype none

// 3x3 rank filter: median, minimum or maximum of a window of gray pixels.
// Input channel (in_*): one full window plus an on_border flag per item.
// Border windows return the center pixel unchanged.
// Output channel (out_*): one filtered pixel per input item, in order.
// Config: APB-style write to byte 0 sets rank_mode (0 median, 1 minimum,
// 2 maximum, 3 as median); change it only while the pipeline is empty.
// Pipeline: the row-sort lane results are registered in stage 1 when an
// item is accepted, and the merged pixel in the stage 2 output register.
// Throughput is one item per cycle while out_stall is low; each stage
// holds one item, so the block keeps accepting while the output register
// waits on out_stall and stalls its input only when both stages are full.
// Reset clears both stage valid bits and sets rank_mode to median.
module rank_filter_3x3_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire rf3_pkg::pix_t in_top_left,
  input  wire rf3_pkg::pix_t in_top_mid,
  input  wire rf3_pkg::pix_t in_top_right,
  input  wire rf3_pkg::pix_t in_mid_left,
  input  wire rf3_pkg::pix_t in_center,
  input  wire rf3_pkg::pix_t in_mid_right,
  input  wire rf3_pkg::pix_t in_bottom_left,
  input  wire rf3_pkg::pix_t in_bottom_mid,
  input  wire rf3_pkg::pix_t in_bottom_right,
  input  wire                in_on_border,
  output logic               out_valid,
  input  wire                out_stall,
  output rf3_pkg::pix_t      out_filtered,
  input  wire                cfg_psel,
  input  wire                cfg_penable,
  input  wire                cfg_pwrite,
  input  wire                cfg_paddr,
  input  wire [31:0]         cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  logic [1:0]     rank_mode_r;
  logic           cfg_wr;

  rf3_pkg::trio_t row0, row1, row2;
  rf3_pkg::trio_t row0_r, row1_r, row2_r;
  rf3_pkg::pix_t  center_r;
  logic           border_r;
  logic           s1_valid_r;
  rf3_pkg::pix_t  merged;
  rf3_pkg::pix_t  out_filtered_r;
  logic           out_valid_r;
  logic           out_ready, s1_ready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == rf3_pkg::ADDR_RANK_MODE);
  assign cfg_prdata = (cfg_paddr == rf3_pkg::ADDR_RANK_MODE) ?
                      {30'd0, rank_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_mode_r <= rf3_pkg::MODE_MEDIAN;
    end else if (cfg_wr) begin
      rank_mode_r <= cfg_pwdata[1:0];
    end
  end

  rf3_lane u_lane0 (.a(in_top_left),    .b(in_top_mid),    .c(in_top_right),
                    .sorted(row0));
  rf3_lane u_lane1 (.a(in_mid_left),    .b(in_center),     .c(in_mid_right),
                    .sorted(row1));
  rf3_lane u_lane2 (.a(in_bottom_left), .b(in_bottom_mid), .c(in_bottom_right),
                    .sorted(row2));

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_stall  = !s1_ready;

  // Stage 1: lane results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
    if (s1_ready && in_valid) begin
      row0_r   <= row0;
      row1_r   <= row1;
      row2_r   <= row2;
      center_r <= in_center;
      border_r <= in_on_border;
    end
  end

  rf3_merge u_merge (
    .row0      (row0_r),
    .row1      (row1_r),
    .row2      (row2_r),
    .rank_mode (rank_mode_r),
    .center    (center_r),
    .on_border (border_r),
    .filtered  (merged)
  );

  // Stage 2: output register, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
    if (out_ready && s1_valid_r) begin
      out_filtered_r <= merged;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

endmodule

`default_nettype wire

>>> rtl/rf3_checker.sv
`default_nettype none

module rf3_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input wire rf3_pkg::pix_t in_center,
  input wire                in_on_border,
  input wire                out_valid,
  input wire                out_stall,
  input wire rf3_pkg::pix_t out_filtered
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled item dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_filtered))
    else $error("stalled item changed");

  // A border window passes its center through to out_filtered when the output does not stall
  a_border_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_on_border) ##1 !out_stall
      |=> out_valid && (out_filtered == $past(in_center, 2)))
    else $error("border center not passed through");

endmodule

bind rank_filter_3x3_unit rf3_checker u_rf3_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_center    (in_center),
  .in_on_border (in_on_border),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_filtered (out_filtered)
);

`default_nettype wire
